// ===== rtl/cmc_pkg.sv =====
`default_nettype none

package cmc_pkg;

    // internal magnitudes are unsigned with 30 fraction bits
    localparam int QI = 30;
    localparam logic [30:0] ONE_Q = 31'h4000_0000;
    localparam logic [29:0] HALF_Q = 30'h2000_0000;

    // angle and scale constants
    localparam logic [30:0] PI_HALF_Q = 31'd1686629713;
    localparam logic [30:0] PI_SIXTH_Q = 31'd562209904;
    localparam logic [30:0] SIX_OVER_PI_Q = 31'd2050695827;
    localparam logic [30:0] TWO_OVER_PI_Q = 31'd683565276;

    localparam int SIN_STEPS = 6;
    localparam int ASIN_TERMS = 16;
    localparam int ROOT_BITS = 29;

    // sine recurrence divisors and floor(2^32 / d)
    localparam logic [7:0] SIN_DEN [SIN_STEPS] = '{
        8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
    };
    localparam logic [29:0] SIN_REC [SIN_STEPS] = '{
        30'd27531841, 30'd39045157, 30'd59652323,
        30'd102261126, 30'd214748364, 30'd715827882
    };

    // arcsine series: odd^2, (2n+2)(2n+3) and floor(odd^2 * 2^30 / den)
    localparam logic [9:0] SER_NUM [ASIN_TERMS] = '{
        10'd1, 10'd9, 10'd25, 10'd49, 10'd81, 10'd121, 10'd169, 10'd225,
        10'd289, 10'd361, 10'd441, 10'd529, 10'd625, 10'd729, 10'd841, 10'd961
    };
    localparam logic [10:0] SER_DEN [ASIN_TERMS] = '{
        11'd6, 11'd20, 11'd42, 11'd72, 11'd110, 11'd156, 11'd210, 11'd272,
        11'd342, 11'd420, 11'd506, 11'd600, 11'd702, 11'd812, 11'd930, 11'd1056
    };
    localparam logic [29:0] SER_REC [ASIN_TERMS] = '{
        30'd178956970, 30'd483183820, 30'd639132038, 30'd730740963,
        30'd790664434, 30'd832838209, 30'd864106515, 30'd888205552,
        30'd907343237, 30'd922906663, 30'd935810562, 30'd946682374,
        30'd955966723, 30'd963987425, 30'd970985886, 30'd977145731
    };

    // conversion selector codes
    typedef enum logic [2:0] {
        CONV_P2S   = 3'd0,
        CONV_P2K   = 3'd1,
        CONV_S2P   = 3'd2,
        CONV_S2K   = 3'd3,
        CONV_K2P   = 3'd4,
        CONV_K2S   = 3'd5,
        CONV_IDENT = 3'd6
    } cmc_kind_t;

    // payload through the sine cells
    typedef struct packed {
        logic        neg;
        cmc_kind_t   kind;
        logic [30:0] m;
        logic [30:0] a;
        logic [31:0] a2;
        logic [30:0] t;
    } cmc_sin_t;

    // payload through the square root cells
    typedef struct packed {
        logic        neg;
        cmc_kind_t   kind;
        logic [32:0] direct;
        logic        big;
        logic [29:0] ysm;
        logic [57:0] v;
        logic [30:0] rem;
        logic [28:0] root;
    } cmc_root_t;

    // payload through the arcsine series cells
    typedef struct packed {
        logic        neg;
        cmc_kind_t   kind;
        logic [32:0] direct;
        logic        big;
        logic [28:0] z2;
        logic [29:0] term;
        logic [30:0] sum;
    } cmc_ser_t;

endpackage

`default_nettype wire

// ===== rtl/cmc_sin_cell.sv =====
`default_nettype none

module cmc_sin_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cmc_pkg::cmc_sin_t in_data,
    input  logic [7:0]        den,
    input  logic [29:0]       rec,
    output logic              out_valid,
    output cmc_pkg::cmc_sin_t out_data
);

    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    cmc_pkg::cmc_sin_t d1_reg;
    cmc_pkg::cmc_sin_t d2_reg;
    cmc_pkg::cmc_sin_t d3_reg;
    logic [31:0]       x1_reg;
    logic [31:0]       x2_reg;
    logic [29:0]       q2_reg;

    logic [62:0]       prod_at;
    logic [31:0]       x1_next;
    logic [61:0]       prod_xr;
    logic [29:0]       q2_next;
    logic [37:0]       qd;
    logic [37:0]       diff;
    logic [29:0]       quot;
    cmc_pkg::cmc_sin_t d3_next;

    // product a2 * t
    always_comb
    begin
        prod_at = in_data.a2 * in_data.t;
        x1_next = prod_at[61:30];
    end

    // quotient estimate by reciprocal, at most one low
    always_comb
    begin
        prod_xr = x1_reg * rec;
        q2_next = prod_xr[61:32];
    end

    // correct quotient and form the next t
    always_comb
    begin
        qd = q2_reg * den;
        diff = {6'd0, x2_reg} - qd;
        quot = q2_reg + {29'd0, (diff >= {30'd0, den})};
        d3_next = d2_reg;
        d3_next.t = cmc_pkg::ONE_Q - {1'b0, quot};
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg <= in_data;
            x1_reg <= x1_next;
            d2_reg <= d1_reg;
            x2_reg <= x1_reg;
            q2_reg <= q2_next;
            d3_reg <= d3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data = d3_reg;

endmodule

`default_nettype wire

// ===== rtl/cmc_root_cell.sv =====
`default_nettype none

module cmc_root_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  cmc_pkg::cmc_root_t in_data,
    output logic               out_valid,
    output cmc_pkg::cmc_root_t out_data
);

    logic               v_reg;
    cmc_pkg::cmc_root_t d_reg;

    logic [32:0]        rem_t;
    logic [30:0]        trial;
    logic               ge;
    logic [32:0]        rem_sub;
    cmc_pkg::cmc_root_t d_next;

    // one result bit per cell, two radicand bits shifted in
    always_comb
    begin
        rem_t = {in_data.rem, in_data.v[57:56]};
        trial = {in_data.root, 2'b01};
        ge = (rem_t >= {2'b00, trial});
        rem_sub = rem_t - {2'b00, trial};
        d_next = in_data;
        d_next.rem = ge ? rem_sub[30:0] : rem_t[30:0];
        d_next.root = {in_data.root[27:0], ge};
        d_next.v = {in_data.v[55:0], 2'b00};
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data = d_reg;

endmodule

`default_nettype wire

// ===== rtl/cmc_term_cell.sv =====
`default_nettype none

module cmc_term_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cmc_pkg::cmc_ser_t in_data,
    input  logic [9:0]        num,
    input  logic [10:0]       den,
    input  logic [29:0]       rec,
    output logic              out_valid,
    output cmc_pkg::cmc_ser_t out_data
);

    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    cmc_pkg::cmc_ser_t d1_reg;
    cmc_pkg::cmc_ser_t d2_reg;
    cmc_pkg::cmc_ser_t d3_reg;
    logic [27:0]       p1_reg;
    logic [27:0]       p2_reg;
    logic [27:0]       q2_reg;

    logic [58:0]       prod_tz;
    logic [27:0]       p1_next;
    logic [57:0]       prod_pr;
    logic [27:0]       q2_next;
    logic [37:0]       pc;
    logic [38:0]       qd;
    logic [38:0]       diff;
    logic [27:0]       quot;
    cmc_pkg::cmc_ser_t d3_next;

    // previous term times z^2
    always_comb
    begin
        prod_tz = in_data.term * in_data.z2;
        p1_next = prod_tz[57:30];
    end

    // estimate of p * num / den, at most one low
    always_comb
    begin
        prod_pr = p1_reg * rec;
        q2_next = prod_pr[57:30];
    end

    // correct the quotient and accumulate
    always_comb
    begin
        pc = p2_reg * num;
        qd = q2_reg * den;
        diff = {1'b0, pc} - qd;
        quot = q2_reg + {27'd0, (diff >= {28'd0, den})};
        d3_next = d2_reg;
        d3_next.term = {2'b00, quot};
        d3_next.sum = d2_reg.sum + {3'b000, quot};
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg <= in_data;
            p1_reg <= p1_next;
            d2_reg <= d1_reg;
            p2_reg <= p1_reg;
            q2_reg <= q2_next;
            d3_reg <= d3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data = d3_reg;

endmodule

`default_nettype wire

// ===== rtl/correlation_measure_converter_unit.sv =====
`default_nettype none

// Converts one correlation coefficient per cycle between Pearson, Spearman
// and Kendall measures (sine and arcsine relations), selected by the
// conversion_kind register written on the cfg port (reset: identity).
// Inputs outside -1..+1 are saturated first. The datapath is a fixed
// pipeline: three entry stages, six sine cells of three stages each, two
// stages to form the arcsine argument, 29 square-root cells of one stage,
// one stage for z^2, sixteen series cells of three stages each and three
// exit stages. A new request is taken every cycle while in_stall is low; a
// stall on the output freezes the whole pipeline and a one-entry skid buffer
// catches the request in flight, after which in_stall stays high until the
// stall clears.
module correlation_measure_converter_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FRAC_BITS+1:0]   corr_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [FRAC_BITS+1:0]   corr_out,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_data
);

    localparam int W = FRAC_BITS + 2;
    localparam int SH = cmc_pkg::QI - FRAC_BITS;
    localparam logic [W-1:0] ONE_FW = W'(1) << FRAC_BITS;
    localparam logic [33:0] ONE_F34 = 34'd1 << FRAC_BITS;
    localparam logic [33:0] RND_HALF = 34'((64'd1 << SH) >> 1);

    // configuration
    cmc_pkg::cmc_kind_t kind_reg;

    // skid buffer
    logic               skid_valid_reg;
    logic               skid_valid_next;
    logic [W-1:0]       skid_data_reg;
    logic               accept;
    logic               src_valid;
    logic [W-1:0]       src_data;
    logic               en;

    // entry stages
    logic               s0_valid_reg;
    logic               s0_neg_reg;
    cmc_pkg::cmc_kind_t s0_kind_reg;
    logic [30:0]        s0_m_reg;
    logic               s0_neg_next;
    logic [W-1:0]       s0_mag;
    logic [W-1:0]       s0_sat;
    logic [30:0]        s0_m_next;

    logic               s1_valid_reg;
    logic               s1_neg_reg;
    cmc_pkg::cmc_kind_t s1_kind_reg;
    logic [30:0]        s1_m_reg;
    logic [30:0]        s1_a_reg;
    logic [61:0]        s1_prod;
    logic [30:0]        s1_a_next;

    logic               s2_valid_reg;
    cmc_pkg::cmc_sin_t  s2_data_reg;
    logic [61:0]        s2_prod;
    cmc_pkg::cmc_sin_t  s2_data_next;

    // sine chain
    logic               sin_v [cmc_pkg::SIN_STEPS+1];
    cmc_pkg::cmc_sin_t  sin_d [cmc_pkg::SIN_STEPS+1];

    // sine output and arcsine argument
    logic               s3_valid_reg;
    logic               s3_neg_reg;
    cmc_pkg::cmc_kind_t s3_kind_reg;
    logic [30:0]        s3_m_reg;
    logic [31:0]        s3_sv_reg;
    logic [61:0]        s3_prod;

    logic               s4_valid_reg;
    cmc_pkg::cmc_root_t s4_data_reg;
    cmc_pkg::cmc_root_t s4_data_next;
    logic [32:0]        s4_yraw;
    logic [30:0]        s4_y;
    logic [30:0]        s4_diff;

    // square root chain
    logic               root_v [cmc_pkg::ROOT_BITS+1];
    cmc_pkg::cmc_root_t root_d [cmc_pkg::ROOT_BITS+1];

    // series setup
    logic               s5_valid_reg;
    cmc_pkg::cmc_ser_t  s5_data_reg;
    cmc_pkg::cmc_ser_t  s5_data_next;
    logic [29:0]        s5_z;
    logic [59:0]        s5_prod;

    // series chain
    logic               ser_v [cmc_pkg::ASIN_TERMS+1];
    cmc_pkg::cmc_ser_t  ser_d [cmc_pkg::ASIN_TERMS+1];

    // exit stages
    logic               f1_valid_reg;
    logic               f1_neg_reg;
    cmc_pkg::cmc_kind_t f1_kind_reg;
    logic [32:0]        f1_direct_reg;
    logic [30:0]        f1_asin_reg;
    logic [31:0]        f1_twice;
    logic [30:0]        f1_asin_next;

    logic               f2_valid_reg;
    logic               f2_neg_reg;
    logic [32:0]        f2_r_reg;
    logic [30:0]        f2_coef;
    logic [61:0]        f2_prod;
    logic [32:0]        f2_r_next;

    logic               out_valid_reg;
    logic [W-1:0]       corr_out_reg;
    logic [33:0]        f3_rnd;
    logic [33:0]        f3_sat;
    logic [W-1:0]       f3_mag;
    logic [W-1:0]       f3_out_next;

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= cmc_pkg::CONV_IDENT;
        end
        else if (cfg_valid)
        begin
            kind_reg <= cmc_pkg::cmc_kind_t'(cfg_data);
        end
    end

    // pipeline advances unless the output holds a stalled result
    assign en = !(out_valid_reg && out_stall);

    // skid buffer in front of the pipeline
    assign in_stall = skid_valid_reg;
    assign accept = in_valid && !skid_valid_reg;
    assign src_valid = skid_valid_reg || accept;
    assign src_data = skid_valid_reg ? skid_data_reg : corr_in;

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (en)
        begin
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && accept)
        begin
            skid_data_reg <= corr_in;
        end
    end

    // stage 0: magnitude, saturate to one, move to q30
    always_comb
    begin
        s0_neg_next = src_data[W-1];
        s0_mag = s0_neg_next ? (~src_data + W'(1)) : src_data;
        s0_sat = (s0_mag > ONE_FW) ? ONE_FW : s0_mag;
        s0_m_next = 31'(s0_sat) << SH;
    end

    // stage 1: angle scaling for sine paths
    always_comb
    begin
        case (s0_kind_reg)
            cmc_pkg::CONV_S2P, cmc_pkg::CONV_S2K:
            begin
                s1_prod = s0_m_reg * cmc_pkg::PI_SIXTH_Q;
                s1_a_next = s1_prod[60:30];
            end
            cmc_pkg::CONV_K2P, cmc_pkg::CONV_K2S:
            begin
                s1_prod = s0_m_reg * cmc_pkg::PI_HALF_Q;
                s1_a_next = s1_prod[60:30];
            end
            default:
            begin
                s1_prod = '0;
                s1_a_next = s0_m_reg;
            end
        endcase
    end

    // stage 2: angle squared, start t at one
    always_comb
    begin
        s2_prod = s1_a_reg * s1_a_reg;
        s2_data_next.neg = s1_neg_reg;
        s2_data_next.kind = s1_kind_reg;
        s2_data_next.m = s1_m_reg;
        s2_data_next.a = s1_a_reg;
        s2_data_next.a2 = s2_prod[61:30];
        s2_data_next.t = cmc_pkg::ONE_Q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= src_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_neg_reg <= s0_neg_next;
            s0_kind_reg <= kind_reg;
            s0_m_reg <= s0_m_next;
            s1_neg_reg <= s0_neg_reg;
            s1_kind_reg <= s0_kind_reg;
            s1_m_reg <= s0_m_reg;
            s1_a_reg <= s1_a_next;
            s2_data_reg <= s2_data_next;
        end
    end

    // sine recurrence cells
    assign sin_v[0] = s2_valid_reg;
    assign sin_d[0] = s2_data_reg;

    for (genvar i = 0; i < cmc_pkg::SIN_STEPS; i++)
    begin : g_sin
        cmc_sin_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sin_v[i]),
            .in_data   (sin_d[i]),
            .den       (cmc_pkg::SIN_DEN[i]),
            .rec       (cmc_pkg::SIN_REC[i]),
            .out_valid (sin_v[i+1]),
            .out_data  (sin_d[i+1])
        );
    end

    // stage 3: sine value a * t
    assign s3_prod = sin_d[cmc_pkg::SIN_STEPS].a * sin_d[cmc_pkg::SIN_STEPS].t;

    // stage 4: direct results and arcsine argument
    always_comb
    begin
        case (s3_kind_reg)
            cmc_pkg::CONV_S2P:
            begin
                s4_data_next.direct = {s3_sv_reg, 1'b0};
                s4_yraw = 33'(s3_m_reg);
            end
            cmc_pkg::CONV_K2P:
            begin
                s4_data_next.direct = {1'b0, s3_sv_reg};
                s4_yraw = 33'(s3_m_reg);
            end
            cmc_pkg::CONV_P2S:
            begin
                s4_data_next.direct = 33'(s3_m_reg);
                s4_yraw = 33'(s3_m_reg >> 1);
            end
            cmc_pkg::CONV_S2K:
            begin
                s4_data_next.direct = 33'(s3_m_reg);
                s4_yraw = {s3_sv_reg, 1'b0};
            end
            cmc_pkg::CONV_K2S:
            begin
                s4_data_next.direct = 33'(s3_m_reg);
                s4_yraw = 33'(s3_sv_reg >> 1);
            end
            default:
            begin
                s4_data_next.direct = 33'(s3_m_reg);
                s4_yraw = 33'(s3_m_reg);
            end
        endcase
        s4_y = (s4_yraw > 33'(cmc_pkg::ONE_Q)) ? cmc_pkg::ONE_Q : s4_yraw[30:0];
        s4_diff = cmc_pkg::ONE_Q - s4_y;
        s4_data_next.neg = s3_neg_reg;
        s4_data_next.kind = s3_kind_reg;
        s4_data_next.big = (s4_y > {1'b0, cmc_pkg::HALF_Q});
        s4_data_next.ysm = s4_y[29:0];
        s4_data_next.v = {s4_diff[28:1], 30'd0};
        s4_data_next.rem = '0;
        s4_data_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= sin_v[cmc_pkg::SIN_STEPS];
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_neg_reg <= sin_d[cmc_pkg::SIN_STEPS].neg;
            s3_kind_reg <= sin_d[cmc_pkg::SIN_STEPS].kind;
            s3_m_reg <= sin_d[cmc_pkg::SIN_STEPS].m;
            s3_sv_reg <= s3_prod[61:30];
            s4_data_reg <= s4_data_next;
        end
    end

    // square root cells, one result bit each
    assign root_v[0] = s4_valid_reg;
    assign root_d[0] = s4_data_reg;

    for (genvar i = 0; i < cmc_pkg::ROOT_BITS; i++)
    begin : g_root
        cmc_root_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (root_v[i]),
            .in_data   (root_d[i]),
            .out_valid (root_v[i+1]),
            .out_data  (root_d[i+1])
        );
    end

    // stage 5: series argument and its square
    always_comb
    begin
        s5_z = root_d[cmc_pkg::ROOT_BITS].big ? {1'b0, root_d[cmc_pkg::ROOT_BITS].root}
                                               : root_d[cmc_pkg::ROOT_BITS].ysm;
        s5_prod = s5_z * s5_z;
        s5_data_next.neg = root_d[cmc_pkg::ROOT_BITS].neg;
        s5_data_next.kind = root_d[cmc_pkg::ROOT_BITS].kind;
        s5_data_next.direct = root_d[cmc_pkg::ROOT_BITS].direct;
        s5_data_next.big = root_d[cmc_pkg::ROOT_BITS].big;
        s5_data_next.z2 = s5_prod[58:30];
        s5_data_next.term = s5_z;
        s5_data_next.sum = {1'b0, s5_z};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= root_v[cmc_pkg::ROOT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_data_reg <= s5_data_next;
        end
    end

    // arcsine series cells, one term each
    assign ser_v[0] = s5_valid_reg;
    assign ser_d[0] = s5_data_reg;

    for (genvar i = 0; i < cmc_pkg::ASIN_TERMS; i++)
    begin : g_term
        cmc_term_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (ser_v[i]),
            .in_data   (ser_d[i]),
            .num       (cmc_pkg::SER_NUM[i]),
            .den       (cmc_pkg::SER_DEN[i]),
            .rec       (cmc_pkg::SER_REC[i]),
            .out_valid (ser_v[i+1]),
            .out_data  (ser_d[i+1])
        );
    end

    // exit stage 1: fold the large-argument arcsine back
    always_comb
    begin
        f1_twice = {ser_d[cmc_pkg::ASIN_TERMS].sum, 1'b0};
        if (!ser_d[cmc_pkg::ASIN_TERMS].big)
        begin
            f1_asin_next = ser_d[cmc_pkg::ASIN_TERMS].sum;
        end
        else if (f1_twice > {1'b0, cmc_pkg::PI_HALF_Q})
        begin
            f1_asin_next = '0;
        end
        else
        begin
            f1_asin_next = cmc_pkg::PI_HALF_Q - f1_twice[30:0];
        end
    end

    // exit stage 2: scale the angle and select the result
    always_comb
    begin
        if (f1_kind_reg == cmc_pkg::CONV_P2S || f1_kind_reg == cmc_pkg::CONV_K2S)
        begin
            f2_coef = cmc_pkg::SIX_OVER_PI_Q;
        end
        else
        begin
            f2_coef = cmc_pkg::TWO_OVER_PI_Q;
        end
        f2_prod = f1_asin_reg * f2_coef;
        case (f1_kind_reg)
            cmc_pkg::CONV_P2S, cmc_pkg::CONV_P2K, cmc_pkg::CONV_S2K, cmc_pkg::CONV_K2S:
            begin
                f2_r_next = {1'b0, f2_prod[61:30]};
            end
            default:
            begin
                f2_r_next = f1_direct_reg;
            end
        endcase
    end

    // exit stage 3: round, saturate and restore the sign
    always_comb
    begin
        f3_rnd = (34'(f2_r_reg) + RND_HALF) >> SH;
        f3_sat = (f3_rnd > ONE_F34) ? ONE_F34 : f3_rnd;
        f3_mag = f3_sat[W-1:0];
        f3_out_next = (f2_neg_reg && (f3_mag != '0)) ? (~f3_mag + W'(1)) : f3_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= ser_v[cmc_pkg::ASIN_TERMS];
            f2_valid_reg <= f1_valid_reg;
            out_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_neg_reg <= ser_d[cmc_pkg::ASIN_TERMS].neg;
            f1_kind_reg <= ser_d[cmc_pkg::ASIN_TERMS].kind;
            f1_direct_reg <= ser_d[cmc_pkg::ASIN_TERMS].direct;
            f1_asin_reg <= f1_asin_next;
            f2_neg_reg <= f1_neg_reg;
            f2_r_reg <= f2_r_next;
            corr_out_reg <= f3_out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign corr_out = corr_out_reg;

endmodule

`default_nettype wire
